// File: rtl/core/bbe_pkg.sv
// Shared types and constants for the Bellman backup engine.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package bbe_pkg;

  // Field widths of one transition beat and of one result beat
  localparam int STATE_W  = 10;
  localparam int ACTION_W = 8;
  localparam int PROB_W   = 17;
  localparam int VALUE_W  = 32;
  localparam int DISC_W   = 17;

  // Packed stream widths; the tdata widths are padded to whole bytes
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 56;

  // Arithmetic widths: discount product, reward sum, term and accumulator
  localparam int DV_W   = 49;
  localparam int SUM_W  = 34;
  localparam int TERM_W = 35;
  localparam int ACC_W  = 64;

  localparam logic [DISC_W-1:0] DISC_RESET = 17'd58982;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_DV,
    ST_MUL_TERM,
    ST_ACC,
    ST_CLOSE
  } bbe_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic mul_dv;
    logic mul_term;
    logic acc;
    logic close;
  } bbe_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic closing;
    logic last_action;
    logic out_busy;
  } bbe_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/bbe_ctrl.sv
// Controller state machine of the Bellman backup engine.
// Depends on bbe_pkg; drives the datapath through bbe_cmd_t.
`default_nettype none

module bbe_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire bbe_pkg::bbe_sts_t sts,
  output bbe_pkg::bbe_cmd_t     cmd
);
  import bbe_pkg::*;

  bbe_state_t state_r;
  bbe_state_t state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MUL_DV;
      end
      ST_MUL_DV:   state_nxt = ST_MUL_TERM;
      ST_MUL_TERM: state_nxt = ST_ACC;
      ST_ACC: begin
        state_nxt = sts.closing ? ST_CLOSE : ST_IDLE;
      end
      ST_CLOSE: begin
        // hold while a result must go out and the output slot is taken
        if (!(sts.last_action && sts.out_busy)) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_we = 1'b1;
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_MUL_DV:   cmd.mul_dv   = 1'b1;
      ST_MUL_TERM: cmd.mul_term = 1'b1;
      ST_ACC:      cmd.acc      = 1'b1;
      ST_CLOSE:    cmd.close    = !(sts.last_action && sts.out_busy);
      default: begin
        cmd       = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/bbe_datapath.sv
// Datapath of the Bellman backup engine: value table, multipliers,
// accumulator, running maximum, output register and discount register.
// Depends on bbe_pkg; steered by bbe_ctrl through bbe_cmd_t.
`default_nettype none

module bbe_datapath #(
  parameter int NUM_STATES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bbe_pkg::bbe_cmd_t                cmd,
  output bbe_pkg::bbe_sts_t                     sts,
  input  wire logic [bbe_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic [bbe_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                             in_tlast,
  input  wire logic                             cfg_valid,
  input  wire logic [bbe_pkg::DISC_W-1:0]       cfg_data,
  output logic      [bbe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready
);
  import bbe_pkg::*;

  localparam int ADDR_W = $clog2(NUM_STATES);

  // Value table
  logic [VALUE_W-1:0] mem [NUM_STATES];

  // Captured beat
  logic [STATE_W-1:0]  st_r;
  logic [ACTION_W-1:0] act_r;
  logic                succ_ok_r;
  logic [PROB_W-1:0]   prob_r;
  logic [VALUE_W-1:0]  rew_r;
  logic                has_r;
  logic                lsucc_r;
  logic                lact_r;

  logic [VALUE_W-1:0]  rd_data_r;
  logic [DV_W-1:0]     dv_r;
  logic [TERM_W-1:0]   term_r;
  logic [ACC_W-1:0]    acc_r;
  logic [VALUE_W-1:0]  run_max_r;
  logic [ACTION_W-1:0] best_act_r;
  logic                max_valid_r;
  logic                sat_seen_r;
  logic [DISC_W-1:0]   disc_r;
  logic [ADDR_W-1:0]   clr_addr_r;

  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_sat_r;
  logic                   out_valid_r;

  // Input fields
  logic [STATE_W-1:0]  in_st;
  logic [ACTION_W-1:0] in_act;
  logic [STATE_W-1:0]  in_succ;
  logic [PROB_W-1:0]   in_prob;
  logic [VALUE_W-1:0]  in_rew;

  assign in_st   = in_tdata[9:0];
  assign in_act  = in_tdata[17:10];
  assign in_succ = in_tdata[27:18];
  assign in_prob = in_tdata[44:28];
  assign in_rew  = in_tdata[76:45];

  // Arithmetic
  logic signed [VALUE_W-1:0] succ_val;
  logic signed [49:0]        dv_full;
  logic signed [32:0]        dv_q;
  logic signed [SUM_W-1:0]   sum;
  logic signed [50:0]        term_full;
  logic [ACC_W-1:0]          acc_add;
  logic                      clip_hi;
  logic                      clip_lo;
  logic [VALUE_W-1:0]        q;
  logic                      take;
  logic [VALUE_W-1:0]        max_sel;
  logic [ACTION_W-1:0]       act_sel;
  logic                      sat_sel;
  logic                      st_ok;
  logic                      emit;

  assign succ_val  = succ_ok_r ? $signed(rd_data_r) : '0;
  assign dv_full   = $signed({{32{1'b0}}, disc_r}) * $signed({{18{succ_val[31]}}, succ_val});
  assign dv_q      = $signed(dv_r[48:16]);
  assign sum       = $signed({rew_r[31], rew_r[31], rew_r}) + $signed({dv_q[32], dv_q});
  assign term_full = $signed({{34{1'b0}}, prob_r}) * $signed({{17{sum[SUM_W-1]}}, sum});
  assign acc_add   = has_r ? acc_r + {{(ACC_W-TERM_W){term_r[TERM_W-1]}}, term_r} : acc_r;

  // Clip the closed Q value to 32 bits
  assign clip_hi = !acc_r[63] && (acc_r[62:31] != '0);
  assign clip_lo = acc_r[63] && (acc_r[62:31] != '1);
  always_comb begin
    if (clip_hi) begin
      q = 32'h7fff_ffff;
    end else if (clip_lo) begin
      q = 32'h8000_0000;
    end else begin
      q = acc_r[31:0];
    end
  end

  // First action always taken, later ones only on a strictly larger value
  assign take    = !max_valid_r || ($signed(q) > $signed(run_max_r));
  assign max_sel = take ? q : run_max_r;
  assign act_sel = take ? act_r : best_act_r;
  assign sat_sel = sat_seen_r | clip_hi | clip_lo;
  assign st_ok   = 32'(st_r) < 32'(NUM_STATES);
  assign emit    = cmd.close && lact_r;

  // Table write: clearing pass or state close
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_wa;
  logic [VALUE_W-1:0] mem_wd;

  assign mem_we = cmd.clr_we | (emit & st_ok);
  assign mem_wa = cmd.clr_we ? clr_addr_r : ADDR_W'(st_r);
  assign mem_wd = cmd.clr_we ? '0 : max_sel;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.capture) begin
      rd_data_r <= mem[ADDR_W'(in_succ)];
    end
  end

  // Capture the beat and run the multiply steps
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      st_r      <= in_st;
      act_r     <= in_act;
      succ_ok_r <= 32'(in_succ) < 32'(NUM_STATES);
      prob_r    <= in_prob;
      rew_r     <= in_rew;
      has_r     <= in_tuser[0];
      lsucc_r   <= in_tuser[1];
      lact_r    <= in_tlast;
    end
    if (cmd.mul_dv) begin
      dv_r <= dv_full[DV_W-1:0];
    end
    if (cmd.mul_term) begin
      term_r <= term_full[50:16];
    end
  end

  // Accumulator, running maximum and clearing address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      run_max_r   <= 32'h8000_0000;
      best_act_r  <= '0;
      max_valid_r <= 1'b0;
      sat_seen_r  <= 1'b0;
      clr_addr_r  <= '0;
    end else begin
      if (cmd.clr_we) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.acc) begin
        acc_r <= acc_add;
      end
      if (cmd.close) begin
        acc_r <= '0;
        if (lact_r) begin
          run_max_r   <= 32'h8000_0000;
          best_act_r  <= '0;
          max_valid_r <= 1'b0;
          sat_seen_r  <= 1'b0;
        end else begin
          run_max_r   <= max_sel;
          best_act_r  <= act_sel;
          max_valid_r <= 1'b1;
          sat_seen_r  <= sat_sel;
        end
      end
    end
  end

  // Discount register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disc_r <= DISC_RESET;
    end else if (cfg_valid) begin
      disc_r <= cfg_data;
    end
  end

  // Output register: load on a state close, drop on a taken beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {6'b0, max_sel, act_sel, st_r};
      out_sat_r  <= sat_sel;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tvalid = out_valid_r;

  // Status
  assign sts.clear_last  = clr_addr_r == ADDR_W'(NUM_STATES - 1);
  assign sts.closing     = !has_r || lsucc_r;
  assign sts.last_action = lact_r;
  assign sts.out_busy    = out_valid_r && !out_tready;

endmodule

`default_nettype wire

// File: rtl/core/bellman_backup_engine_top.sv
// Top level of the Bellman backup engine: controller plus datapath.
// Depends on bbe_pkg, bbe_ctrl and bbe_datapath.
`default_nettype none

// Bellman backup engine. Stream in the (action, successor) transitions of one
// state; each action closes on last_successor or on a beat with has_successor
// low, and the state closes on the closing beat that carries tlast. One
// result beat per state gives the best action, its Q16.16 value (also written
// back to the value table) and a saturation flag. After reset the block
// zeroes its value table in a clearing pass, during which in_tready stays low.
// Each transition beat then runs the table read and the two registered
// multiplies in series, then the accumulate and, when it closes an action, the
// compare against the running maximum; only then is the next beat taken.
// A beat that closes a state waits while the previous result is still untaken.
// The discount register may be written at any time the block is idle.
module bellman_backup_engine_top #(
  parameter int NUM_STATES = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // bits: state_index[9:0], action_index[17:10], successor_index[27:18],
  // probability[44:28], reward[76:45], zero fill[79:77]
  input  wire logic [bbe_pkg::IN_TDATA_W-1:0]   in_tdata,
  // bits: has_successor[0], last_successor[1]
  input  wire logic [bbe_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  wire logic                             in_tlast,     // last_action
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // bits: updated_state[9:0], best_action[17:10], best_value[49:18],
  // zero fill[55:50]
  output logic      [bbe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                                  out_tuser,    // saturated
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  input  wire logic [bbe_pkg::DISC_W-1:0]       cfg_data,     // discount
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready
);
  import bbe_pkg::*;

  bbe_cmd_t cmd;
  bbe_sts_t sts;

  assign cfg_ready = 1'b1;

  bbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bbe_datapath #(
    .NUM_STATES (NUM_STATES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

endmodule

`default_nettype wire

// File: rtl/core/bbe_checker.sv
// Port-level checks for the Bellman backup engine, bound to the top level.
// Depends on bbe_pkg for stream widths.
`default_nettype none

module bbe_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [bbe_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire logic                             out_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Stay busy through the read and multiply steps of an accepted beat
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready ##1 !in_tready)
    else $error("beat accepted during multiply steps");

  // Accept nothing while reset starts the clearing pass
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("ready or result right after reset");

  // A new result only appears while a beat is in work
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while idle");

endmodule

bind bellman_backup_engine_top bbe_checker u_bbe_checker (.*);

`default_nettype wire
